FILE: rtl/core/u8e_pkg.sv
// Shared types and constants for the UTF-8 (six-byte form) encoder.
package u8e_pkg;

    localparam int CP_W       = 32;
    localparam int CAP_W      = 24;
    localparam int TOTAL_W    = 24;
    localparam int BYTE_W     = 8;
    localparam int MAX_RES    = 7;
    localparam int MAX_BYTES  = 6;
    localparam int RES_CNT_W  = 3;
    localparam int NBYTE_W    = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;
    localparam int COUNT_BITS_DEF = 24;

    localparam logic [CAP_W-1:0] CAP_RESET = 24'd256;

    localparam logic [CFG_IDX_W-1:0] REG_OUT_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_ONLY   = 1'd1;

    localparam logic [BYTE_W-1:0] LEAD_2 = 8'hc0;
    localparam logic [BYTE_W-1:0] LEAD_3 = 8'he0;
    localparam logic [BYTE_W-1:0] LEAD_4 = 8'hf0;
    localparam logic [BYTE_W-1:0] LEAD_5 = 8'hf8;
    localparam logic [BYTE_W-1:0] LEAD_6 = 8'hfc;
    localparam logic [BYTE_W-1:0] CONT   = 8'h80;
    localparam logic [BYTE_W-1:0] NUL    = 8'h00;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               byte_valid;
        logic               last;
        t_status            status;
        logic               string_done;
        logic [TOTAL_W-1:0] byte_total;
    } t_res;

endpackage

FILE: rtl/core/u8e_if.sv
// Handshake channel interfaces for code points, encoded bytes and register writes.
interface u8e_in_if;
    logic                          valid;
    logic                          ready;
    logic [u8e_pkg::CP_W-1:0]      code_point;
    logic                          final_word;

    modport source (output valid, output code_point, output final_word, input ready);
    modport sink   (input valid, input code_point, input final_word, output ready);
endinterface

interface u8e_out_if;
    logic                          valid;
    logic                          ready;
    logic [u8e_pkg::BYTE_W-1:0]    out_byte;
    logic                          byte_valid;
    logic                          last;
    logic [1:0]                    status;
    logic                          string_done;
    logic [u8e_pkg::TOTAL_W-1:0]   byte_total;

    modport source (output valid, output out_byte, output byte_valid, output last,
                    output status, output string_done, output byte_total, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input last,
                    input status, input string_done, input byte_total, output ready);
endinterface

interface u8e_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [u8e_pkg::CFG_IDX_W-1:0]     index;
    logic [u8e_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/utf8_encoder_ucs4_unit.sv
// Top level of the UTF-8 encoder: code point in, serialized bytes and string status out.
//
// One code point is taken per transfer and encoded in the cycle it is accepted into a
// result buffer of up to seven results (six bytes plus the terminating NUL); the buffer
// then drains one result per output transfer. A code point that yields one result (a
// single byte, a count-only word, an error or a bare terminator) therefore moves at one
// per cycle while the output is not stalled; one that yields k results holds the input
// until its last result transfers, since the next code point is taken in the cycle the
// last result of the previous one transfers. The first output result is presented in
// the cycle after the input transfer. Items dropped after an error produce no result.
// Register writes are always accepted and must be made while no results are pending.
module utf8_encoder_ucs4_unit #(
    parameter int COUNT_BITS = u8e_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u8e_in_if.sink      i_in,
    u8e_cfg_if.sink     i_cfg,
    u8e_out_if.source   o_out
);

    localparam int SUM_W = COUNT_BITS + 1;
    localparam int CMP_W = (SUM_W > u8e_pkg::CAP_W + 1) ? SUM_W : u8e_pkg::CAP_W + 1;

    logic [u8e_pkg::CAP_W-1:0]         r_capacity;
    logic                              r_count_only;
    logic [COUNT_BITS-1:0]             r_used;
    logic                              r_aborted;
    logic [u8e_pkg::RES_CNT_W-1:0]     r_cnt;
    u8e_pkg::t_res                     r_res [u8e_pkg::MAX_RES];

    logic [COUNT_BITS-1:0]             n_used;
    logic                              n_aborted;
    logic [u8e_pkg::RES_CNT_W-1:0]     n_cnt;
    u8e_pkg::t_res                     n_res [u8e_pkg::MAX_RES];

    logic                              in_fire;
    logic                              out_fire;
    logic [u8e_pkg::CP_W-1:0]          cp;
    logic                              ends;
    logic                              cp_zero;
    logic [u8e_pkg::NBYTE_W-1:0]       nbytes;
    logic [u8e_pkg::CAP_W-1:0]         allowed;
    logic [SUM_W-1:0]                  sum;
    logic [COUNT_BITS-1:0]             sum_sat;
    logic                              over;
    logic [u8e_pkg::TOTAL_W-1:0]       tot_old;
    logic [u8e_pkg::TOTAL_W-1:0]       tot_new;
    logic [u8e_pkg::BYTE_W-1:0]        lead;
    logic [u8e_pkg::BYTE_W-1:0]        cont [5];
    logic [u8e_pkg::BYTE_W-1:0]        enc [u8e_pkg::MAX_BYTES];
    logic [u8e_pkg::NBYTE_W-1:0]       cont_idx [u8e_pkg::MAX_BYTES];

    assign cp       = i_in.code_point;
    assign cp_zero  = (cp == '0);
    assign ends     = i_in.final_word || cp_zero;
    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;

    assign i_in.ready  = (r_cnt == '0) || ((r_cnt == u8e_pkg::RES_CNT_W'(1)) && o_out.ready);
    assign i_cfg.ready = 1'b1;

    // encoded length
    always_comb begin
        if (cp[30:26] != '0) begin
            nbytes = 3'd6;
        end else if (cp[25:21] != '0) begin
            nbytes = 3'd5;
        end else if (cp[20:16] != '0) begin
            nbytes = 3'd4;
        end else if (cp[15:11] != '0) begin
            nbytes = 3'd3;
        end else if (cp[10:7] != '0) begin
            nbytes = 3'd2;
        end else begin
            nbytes = 3'd1;
        end
    end

    assign allowed = (r_capacity == '0) ? '0 : r_capacity - u8e_pkg::CAP_W'(1);
    assign sum     = {1'b0, r_used} + SUM_W'(nbytes);
    assign sum_sat = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
    assign over    = !r_count_only && (CMP_W'(sum) > CMP_W'(allowed));

    // cap the count into the 24-bit total field
    generate
        if (COUNT_BITS > u8e_pkg::TOTAL_W) begin : g_cap
            assign tot_old = (r_used[COUNT_BITS-1:u8e_pkg::TOTAL_W] != '0) ? '1
                                                : r_used[u8e_pkg::TOTAL_W-1:0];
            assign tot_new = (sum_sat[COUNT_BITS-1:u8e_pkg::TOTAL_W] != '0) ? '1
                                                : sum_sat[u8e_pkg::TOTAL_W-1:0];
        end else begin : g_ext
            assign tot_old = u8e_pkg::TOTAL_W'(r_used);
            assign tot_new = u8e_pkg::TOTAL_W'(sum_sat);
        end
    endgenerate

    // lead and continuation bytes
    always_comb begin
        case (nbytes)
            3'd2:    lead = u8e_pkg::LEAD_2 | {3'b000, cp[10:6]};
            3'd3:    lead = u8e_pkg::LEAD_3 | {4'b0000, cp[15:12]};
            3'd4:    lead = u8e_pkg::LEAD_4 | {5'b00000, cp[20:18]};
            3'd5:    lead = u8e_pkg::LEAD_5 | {6'b000000, cp[25:24]};
            3'd6:    lead = u8e_pkg::LEAD_6 | {7'b0000000, cp[30]};
            default: lead = cp[7:0];
        endcase
    end

    always_comb begin
        for (int k = 0; k < 5; k++) begin
            cont[k] = u8e_pkg::CONT | {2'b00, cp[6*k +: 6]};
        end
        for (int i = 0; i < u8e_pkg::MAX_BYTES; i++) begin
            cont_idx[i] = nbytes - u8e_pkg::NBYTE_W'(1) - u8e_pkg::NBYTE_W'(i);
            if (i == 0) begin
                enc[i] = lead;
            end else if (u8e_pkg::NBYTE_W'(i) < nbytes && cont_idx[i] < 3'd5) begin
                enc[i] = cont[cont_idx[i]];
            end else begin
                enc[i] = u8e_pkg::NUL;
            end
        end
    end

    // build the result set of one code point
    always_comb begin
        for (int j = 0; j < u8e_pkg::MAX_RES; j++) begin
            n_res[j] = '{out_byte: u8e_pkg::NUL, byte_valid: 1'b0, last: 1'b0,
                         status: u8e_pkg::ST_OK, string_done: 1'b0, byte_total: '0};
        end
        n_cnt     = '0;
        n_used    = r_used;
        n_aborted = r_aborted;
        if (r_aborted) begin
            if (ends) begin
                n_aborted = 1'b0;
                n_used    = '0;
            end
        end else if (cp[31]) begin
            n_res[0] = '{out_byte: u8e_pkg::NUL, byte_valid: 1'b0, last: 1'b1,
                         status: u8e_pkg::ST_INVALID, string_done: 1'b1, byte_total: tot_old};
            n_cnt     = u8e_pkg::RES_CNT_W'(1);
            n_used    = '0;
            n_aborted = !ends;
        end else if (cp_zero) begin
            n_res[0] = '{out_byte: u8e_pkg::NUL, byte_valid: !r_count_only, last: 1'b1,
                         status: u8e_pkg::ST_OK, string_done: 1'b1, byte_total: tot_old};
            n_cnt  = u8e_pkg::RES_CNT_W'(1);
            n_used = '0;
        end else if (over) begin
            n_res[0] = '{out_byte: u8e_pkg::NUL, byte_valid: 1'b1, last: 1'b1,
                         status: u8e_pkg::ST_OVERFLOW, string_done: 1'b1, byte_total: tot_old};
            n_cnt     = u8e_pkg::RES_CNT_W'(1);
            n_used    = '0;
            n_aborted = !ends;
        end else if (r_count_only) begin
            n_res[0] = '{out_byte: u8e_pkg::NUL, byte_valid: 1'b0, last: 1'b1,
                         status: u8e_pkg::ST_OK, string_done: ends, byte_total: tot_new};
            n_cnt  = u8e_pkg::RES_CNT_W'(1);
            n_used = ends ? '0 : sum_sat;
        end else begin
            for (int j = 0; j < u8e_pkg::MAX_RES; j++) begin
                if (j < u8e_pkg::MAX_BYTES && u8e_pkg::NBYTE_W'(j) < nbytes) begin
                    n_res[j] = '{out_byte: enc[j], byte_valid: 1'b1,
                                 last: !ends && (u8e_pkg::NBYTE_W'(j + 1) == nbytes),
                                 status: u8e_pkg::ST_OK, string_done: 1'b0,
                                 byte_total: tot_new};
                end else if (ends && u8e_pkg::NBYTE_W'(j) == nbytes) begin
                    n_res[j] = '{out_byte: u8e_pkg::NUL, byte_valid: 1'b1, last: 1'b1,
                                 status: u8e_pkg::ST_OK, string_done: 1'b1,
                                 byte_total: tot_new};
                end
            end
            n_cnt  = ends ? nbytes + u8e_pkg::RES_CNT_W'(1) : nbytes;
            n_used = ends ? '0 : sum_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity   <= u8e_pkg::CAP_RESET;
            r_count_only <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                u8e_pkg::REG_OUT_CAPACITY: r_capacity   <= i_cfg.data[u8e_pkg::CAP_W-1:0];
                u8e_pkg::REG_COUNT_ONLY:   r_count_only <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_aborted <= 1'b0;
            r_cnt     <= '0;
        end else if (in_fire) begin
            r_used    <= n_used;
            r_aborted <= n_aborted;
            r_cnt     <= n_cnt;
        end else if (out_fire) begin
            r_cnt <= r_cnt - u8e_pkg::RES_CNT_W'(1);
        end
    end

    // load on accept, advance one result per output transfer
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_res <= n_res;
        end else if (out_fire) begin
            for (int j = 0; j < u8e_pkg::MAX_RES - 1; j++) begin
                r_res[j] <= r_res[j + 1];
            end
        end
    end

    assign o_out.valid       = (r_cnt != '0);
    assign o_out.out_byte    = r_res[0].out_byte;
    assign o_out.byte_valid  = r_res[0].byte_valid;
    assign o_out.last        = r_res[0].last;
    assign o_out.status      = r_res[0].status;
    assign o_out.string_done = r_res[0].string_done;
    assign o_out.byte_total  = r_res[0].byte_total;

endmodule
